/* rtl/core/tcce_pkg.sv */
// tcce_pkg: screen geometry, character codes, command and status types
// shared by the console engine controller, datapath and top level.
// no dependencies.
package tcce_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // field widths
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int POS_W   = 8;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = 16;
  localparam int FUNC_W  = 2;
  localparam int ADDR_W  = $clog2(CELL_COUNT);
  localparam int SWEEP_W = $clog2(CELL_COUNT + 1);

  // character codes
  localparam logic [CHAR_W-1:0] CH_BLANK        = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_RETURN       = 8'h0D;
  localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'd32;
  localparam logic [CHAR_W-1:0] LAST_PRINTABLE  = 8'd126;
  localparam logic [ATTR_W-1:0] ATTR_RESET      = 8'h07;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUT_CHAR,
    FN_CLEAR,
    FN_WRITE_CELL,
    FN_READ_CELL
  } func_t;

  typedef enum logic [1:0] {
    SW_INIT,
    SW_CLEAR,
    SW_SCROLL
  } sweep_mode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic        capture;
    logic        exec;
    logic        sweep_run;
    sweep_mode_t sweep_mode;
    logic        load_out;
    logic        entry_from_ram;
    logic        latch_entry;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_read;
    logic scroll_req;
    logic sweep_done;
    logic out_free;
  } dp_status_t;

  function automatic logic is_printable(input logic [CHAR_W-1:0] ch);
    return (ch >= FIRST_PRINTABLE) && (ch <= LAST_PRINTABLE);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(r * COLUMNS) + ADDR_W'(c);
  endfunction

endpackage

/* rtl/core/text_console_char_engine.sv */
// text_console_char_engine: top level of the text-mode console engine
// depends on tcce_pkg, tcce_ctrl, tcce_dp
//
// Text console engine holding an 80x25 screen of 16-bit cells (attribute in
// the high byte, character in the low byte) and a cursor. Each input
// transaction carries one command (put_char, clear, write_cell, read_cell)
// and produces exactly one output transaction with the cursor after the
// command and, for read_cell, the stored cell (zero otherwise or when the
// position is off screen). After reset the engine sweeps the whole screen
// memory to blank (0x0720), one cell per cycle, with in_stall high;
// attribute writes are taken during that pass. The screen memory has one
// write port and one registered read port. put_char, write_cell and cursor
// moves are accepted, then executed and the result loaded (or held until
// the output register is free); read_cell adds a registered memory read;
// clear writes one cell per cycle, and a put_char that scrolls reads each
// cell one row down and writes it back the next cycle, the bottom row
// blanked in the same pass. A new transaction is taken while the previous
// result still waits in the output register.
module text_console_char_engine (
  input  logic                          clk,
  input  logic                          rst,
  // attribute register write
  input  logic                          cfg_we,
  input  logic [tcce_pkg::ATTR_W-1:0]   cfg_wdata,
  // command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tcce_pkg::FUNC_W-1:0]   func,
  input  logic [tcce_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcce_pkg::POS_W-1:0]    col,
  input  logic [tcce_pkg::POS_W-1:0]    row,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcce_pkg::COL_W-1:0]    cursor_col,
  output logic [tcce_pkg::ROW_W-1:0]    cursor_row,
  output logic [tcce_pkg::CELL_W-1:0]   cell_entry
);
  import tcce_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // controller: sequences init sweep, execute, read, scroll, clear
  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: screen memory, cursor, attribute and output register
  tcce_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .func       (func),
    .char_code  (char_code),
    .col        (col),
    .row        (row),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .cell_entry (cell_entry)
  );

endmodule

/* rtl/core/tcce_ctrl.sv */
// tcce_ctrl: sequencing state machine of the console engine
// depends on tcce_pkg (state, command and status types)
module tcce_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tcce_pkg::dp_status_t  status,
  output tcce_pkg::dp_cmd_t     cmd
);
  import tcce_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_INIT: begin
        cmd.sweep_run  = 1'b1;
        cmd.sweep_mode = SW_INIT;
        if (status.sweep_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.is_clear) begin
          state_next = ST_CLEAR;
        end else if (status.scroll_req) begin
          state_next = ST_SCROLL;
        end else if (status.is_read) begin
          state_next = ST_READ;
        end else if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_READ: begin
        cmd.latch_entry = 1'b1;
        if (status.out_free) begin
          cmd.load_out       = 1'b1;
          cmd.entry_from_ram = 1'b1;
          state_next         = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_SCROLL: begin
        cmd.sweep_run  = 1'b1;
        cmd.sweep_mode = SW_SCROLL;
        if (status.sweep_done) state_next = ST_HOLD;
      end
      ST_CLEAR: begin
        cmd.sweep_run  = 1'b1;
        cmd.sweep_mode = SW_CLEAR;
        if (status.sweep_done) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_exec_once: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC |=> state != ST_EXEC)
    else $error("execute step lasted more than one cycle");

  a_scroll_to_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCROLL && status.sweep_done) |=> state == ST_HOLD)
    else $error("scroll pass did not end in hold");

  a_load_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("result loaded over a waiting result");

endmodule

/* rtl/core/tcce_dp.sv */
// tcce_dp: console engine datapath: screen memory, cursor, attribute,
// sweep counter for init/clear/scroll, output register
// depends on tcce_pkg
module tcce_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  tcce_pkg::dp_cmd_t             cmd,
  output tcce_pkg::dp_status_t          status,
  input  logic                          cfg_we,
  input  logic [tcce_pkg::ATTR_W-1:0]   cfg_wdata,
  input  logic [tcce_pkg::FUNC_W-1:0]   func,
  input  logic [tcce_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcce_pkg::POS_W-1:0]    col,
  input  logic [tcce_pkg::POS_W-1:0]    row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcce_pkg::COL_W-1:0]    cursor_col,
  output logic [tcce_pkg::ROW_W-1:0]    cursor_row,
  output logic [tcce_pkg::CELL_W-1:0]   cell_entry
);
  import tcce_pkg::*;

  logic [CELL_W-1:0]  cells [CELL_COUNT];
  logic [CELL_W-1:0]  rd_data;

  logic [ATTR_W-1:0]  text_attribute;
  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  func_t              item_func;
  logic [CHAR_W-1:0]  item_char;
  logic [POS_W-1:0]   item_col;
  logic [POS_W-1:0]   item_row;
  logic [CELL_W-1:0]  read_entry;
  logic [SWEEP_W-1:0] sweep_cnt;

  logic [COL_W-1:0]   col_next;
  logic [ROW_W-1:0]   row_next;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [CELL_W-1:0]  wdata;
  logic [ADDR_W-1:0]  raddr;
  logic [CELL_W-1:0]  blank;
  logic               col_max;
  logic               row_last;
  logic               item_in_range;
  logic [ADDR_W-1:0]  item_addr;
  logic [CELL_W-1:0]  ram_entry;
  logic [SWEEP_W-1:0] sweep_prev;
  logic               sweep_done;
  logic               out_free;

  assign blank         = {text_attribute, CH_BLANK};
  assign col_max       = (cur_col == COL_W'(COLUMNS - 1));
  assign row_last      = (cur_row == ROW_W'(ROWS - 1));
  assign item_in_range = (item_col < POS_W'(COLUMNS)) && (item_row < POS_W'(ROWS));
  assign item_addr     = cell_addr(item_row[ROW_W-1:0], item_col[COL_W-1:0]);
  assign ram_entry     = item_in_range ? rd_data : '0;
  assign sweep_prev    = sweep_cnt - SWEEP_W'(1);
  assign out_free      = !out_valid || !out_stall;

  always_comb begin
    unique case (cmd.sweep_mode)
      SW_SCROLL: sweep_done = (sweep_cnt == SWEEP_W'(CELL_COUNT));
      default:   sweep_done = (sweep_cnt == SWEEP_W'(CELL_COUNT - 1));
    endcase
  end

  always_comb begin
    status.is_clear   = (item_func == FN_CLEAR);
    status.is_read    = (item_func == FN_READ_CELL);
    status.scroll_req = (item_func == FN_PUT_CHAR) && row_last &&
                        ((item_char == CH_NEWLINE) ||
                         (is_printable(item_char) && col_max));
    status.sweep_done = sweep_done;
    status.out_free   = out_free;
  end

  // command execution and memory port selection
  always_comb begin
    col_next = cur_col;
    row_next = cur_row;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    raddr    = '0;
    if (cmd.exec) begin
      unique case (item_func)
        FN_PUT_CHAR: begin
          if (item_char == CH_NEWLINE) begin
            col_next = '0;
            if (!row_last) row_next = ROW_W'(cur_row + 1'b1);
          end else if (item_char == CH_BACKSPACE) begin
            if (cur_col != '0) begin
              col_next = COL_W'(cur_col - 1'b1);
              we       = 1'b1;
              waddr    = cell_addr(cur_row, COL_W'(cur_col - 1'b1));
              wdata    = blank;
            end else if (cur_row != '0) begin
              col_next = COL_W'(COLUMNS - 1);
              row_next = ROW_W'(cur_row - 1'b1);
              we       = 1'b1;
              waddr    = cell_addr(ROW_W'(cur_row - 1'b1), COL_W'(COLUMNS - 1));
              wdata    = blank;
            end
          end else if (item_char == CH_RETURN) begin
            col_next = '0;
          end else if (is_printable(item_char)) begin
            we    = 1'b1;
            waddr = cell_addr(cur_row, cur_col);
            wdata = {text_attribute, item_char};
            if (col_max) begin
              col_next = '0;
              if (!row_last) row_next = ROW_W'(cur_row + 1'b1);
            end else begin
              col_next = COL_W'(cur_col + 1'b1);
            end
          end
        end
        FN_CLEAR: begin
          col_next = '0;
          row_next = '0;
        end
        FN_WRITE_CELL: begin
          if (is_printable(item_char) && item_in_range) begin
            we    = 1'b1;
            waddr = item_addr;
            wdata = {text_attribute, item_char};
          end
        end
        FN_READ_CELL: begin
          raddr = item_addr;
        end
        default: begin
        end
      endcase
    end
    if (cmd.sweep_run) begin
      unique case (cmd.sweep_mode)
        SW_INIT: begin
          we    = 1'b1;
          waddr = sweep_cnt[ADDR_W-1:0];
          wdata = {ATTR_RESET, CH_BLANK};
        end
        SW_CLEAR: begin
          we    = 1'b1;
          waddr = sweep_cnt[ADDR_W-1:0];
          wdata = blank;
        end
        SW_SCROLL: begin
          // read one row below, write the cell read in the previous cycle
          if (sweep_cnt < SWEEP_W'(CELL_COUNT - COLUMNS)) begin
            raddr = ADDR_W'(sweep_cnt + SWEEP_W'(COLUMNS));
          end
          we    = (sweep_cnt != '0);
          waddr = sweep_prev[ADDR_W-1:0];
          wdata = (sweep_prev < SWEEP_W'(CELL_COUNT - COLUMNS)) ? rd_data : blank;
        end
        default: begin
        end
      endcase
    end
  end

  // screen memory
  always_ff @(posedge clk) begin
    if (we) cells[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rd_data <= cells[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
      cur_col        <= '0;
      cur_row        <= '0;
      sweep_cnt      <= '0;
    end else begin
      if (cfg_we) text_attribute <= cfg_wdata;
      if (cmd.exec) begin
        cur_col <= col_next;
        cur_row <= row_next;
      end
      if (cmd.sweep_run) begin
        sweep_cnt <= sweep_done ? '0 : SWEEP_W'(sweep_cnt + 1'b1);
      end else begin
        sweep_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_func  <= func_t'(func);
      item_char  <= char_code;
      item_col   <= col;
      item_row   <= row;
      read_entry <= '0;
    end else if (cmd.latch_entry) begin
      read_entry <= ram_entry;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cursor_col <= col_next;
      cursor_row <= row_next;
      cell_entry <= cmd.entry_from_ram ? ram_entry : read_entry;
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_col < COL_W'(COLUMNS)) && (cur_row < ROW_W'(ROWS)))
    else $error("cursor left the screen");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.exec && cmd.sweep_run))
    else $error("execute and sweep drive the memory together");

  a_entry_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> read_entry == '0)
    else $error("read entry not cleared on capture");

endmodule

/* dv/text_console_char_engine_tb.sv */
// text_console_char_engine_tb: self-checking testbench for the text console engine
// depends on tcce_pkg and text_console_char_engine; holds its own screen and cursor
// predictor, a queue-fed command driver, a result monitor and a stall watchdog
`timescale 1ns / 100ps

module text_console_char_engine_tb;
  import tcce_pkg::*;

  // how long the receiver holds off in the last phase, in cycles
  localparam int HOLD_OFF_CYCLES = 400;
  // cycles with no transaction on either channel before the run is abandoned
  // (long enough to cover a scroll, a clear or the pass after reset)
  localparam int WATCHDOG_LIMIT  = 30000;
  // settle time after the last result before a register write or the end
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 20;
  // keep the log short when the design is badly broken
  localparam int MAX_REPORTS     = 40;

  typedef struct {
    func_t            op;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  c;
    logic [POS_W-1:0]  r;
  } console_cmd_t;

  typedef struct {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [CELL_W-1:0] entry;
  } screen_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cfg_we    = 1'b0;
  logic [ATTR_W-1:0] cfg_wdata = '0;

  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] func      = '0;
  logic [CHAR_W-1:0] char_code = '0;
  logic [POS_W-1:0]  col       = '0;
  logic [POS_W-1:0]  row       = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [CELL_W-1:0] cell_entry;

  text_console_char_engine uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .char_code  (char_code),
    .col        (col),
    .row        (row),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .cell_entry (cell_entry)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // screen predictor: its own copy of the cell store, cursor and attribute
  // --------------------------------------------------------------------------
  logic [CELL_W-1:0] screen_model [CELL_COUNT];
  int                model_col;
  int                model_row;
  logic [ATTR_W-1:0] model_attr;

  // cells off screen are silently dropped
  task automatic store_model_cell(input int c, input int r, input logic [CHAR_W-1:0] ch);
    if (c < COLUMNS && r < ROWS) begin
      screen_model[r * COLUMNS + c] = {model_attr, ch};
    end
  endtask

  // blank every cell with the current attribute and home the cursor
  task automatic blank_screen_model();
    for (int i = 0; i < CELL_COUNT; i++) begin
      screen_model[i] = {model_attr, CH_BLANK};
    end
    model_col = 0;
    model_row = 0;
  endtask

  // newline; past the bottom row everything moves up one row and the
  // bottom row comes back blank, cursor stays on the last row
  task automatic advance_model_line();
    model_col = 0;
    model_row++;
    if (model_row >= ROWS) begin
      for (int i = 0; i + COLUMNS < CELL_COUNT; i++) begin
        screen_model[i] = screen_model[i + COLUMNS];
      end
      for (int i = 0; i < COLUMNS; i++) begin
        store_model_cell(i, ROWS - 1, CH_BLANK);
      end
      model_row--;
    end
  endtask

  // apply one command to the model and work out the result it must produce
  task automatic run_console_command(input func_t op, input logic [CHAR_W-1:0] ch,
                                     input logic [POS_W-1:0] c, input logic [POS_W-1:0] r,
                                     output screen_report_t report);
    logic printable;
    printable    = (ch >= FIRST_PRINTABLE) && (ch <= LAST_PRINTABLE);
    report.entry = '0;
    case (op)
      FN_PUT_CHAR: begin
        if (ch == CH_NEWLINE) begin
          advance_model_line();
        end else if (ch == CH_BACKSPACE) begin
          // nothing at the origin, otherwise step back (wrapping up a row)
          // and blank the cell landed on
          if (model_col > 0 || model_row > 0) begin
            if (model_col > 0) begin
              model_col--;
            end else begin
              model_row--;
              model_col = COLUMNS - 1;
            end
            store_model_cell(model_col, model_row, CH_BLANK);
          end
        end else if (ch == CH_RETURN) begin
          model_col = 0;
        end else if (printable) begin
          store_model_cell(model_col, model_row, ch);
          model_col++;
          if (model_col >= COLUMNS) begin
            advance_model_line();
          end
        end
        // any other byte leaves everything alone
      end
      FN_CLEAR: begin
        blank_screen_model();
      end
      FN_WRITE_CELL: begin
        if (printable) begin
          store_model_cell(int'(c), int'(r), ch);
        end
      end
      default: begin
        if (int'(c) < COLUMNS && int'(r) < ROWS) begin
          report.entry = screen_model[int'(r) * COLUMNS + int'(c)];
        end
      end
    endcase
    report.cursor_col = COL_W'(model_col);
    report.cursor_row = ROW_W'(model_row);
  endtask

  // --------------------------------------------------------------------------
  // shared bookkeeping between stimulus, driver and monitor
  // --------------------------------------------------------------------------
  console_cmd_t   commands_to_send [$];
  screen_report_t reports_due [$];
  int             commands_queued = 0;
  int             reports_checked = 0;
  int             mismatch_count  = 0;

  // idle rates in percent and the phase number, set by the stimulus block
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int phase         = 0;

  // --------------------------------------------------------------------------
  // command driver: predicts at acceptance, then offers the next transaction
  // --------------------------------------------------------------------------
  screen_report_t accepted_report;
  console_cmd_t   next_cmd;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        run_console_command(func_t'(func), char_code, col, row, accepted_report);
        reports_due.push_back(accepted_report);
      end
      // payload only moves once the current transaction is gone
      if (!in_valid || !in_stall) begin
        if (commands_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = commands_to_send.pop_front();
          in_valid  <= 1'b1;
          func      <= next_cmd.op;
          char_code <= next_cmd.ch;
          col       <= next_cmd.c;
          row       <= next_cmd.r;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver stall: random, plus one long hold-off at the start of the last
  // phase while the driver keeps offering commands, so the engine backs up
  // --------------------------------------------------------------------------
  int hold_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (phase == 3 && hold_count < HOLD_OFF_CYCLES) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: every result against the oldest prediction
  // --------------------------------------------------------------------------
  screen_report_t want;

  task automatic flag_mismatch(input string field, input int expected_val, input int actual_val);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, expected_val, actual_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $error("result transaction with no command outstanding");
        end
      end else begin
        want = reports_due.pop_front();
        if (cursor_col !== want.cursor_col) begin
          flag_mismatch("cursor_col", want.cursor_col, cursor_col);
        end
        if (cursor_row !== want.cursor_row) begin
          flag_mismatch("cursor_row", want.cursor_row, cursor_row);
        end
        if (cell_entry !== want.entry) begin
          flag_mismatch("cell_entry", want.entry, cell_entry);
        end
        reports_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any transaction on either channel
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic queue_command(input func_t op, input logic [CHAR_W-1:0] ch,
                               input logic [POS_W-1:0] c, input logic [POS_W-1:0] r);
    console_cmd_t cmd;
    cmd.op = op;
    cmd.ch = ch;
    cmd.c  = c;
    cmd.r  = r;
    commands_to_send.push_back(cmd);
    commands_queued++;
  endtask

  // random traffic: mostly put_char text with line control, bursts of
  // newlines to push the cursor to the bottom and scroll, long text runs to
  // wrap lines, cell writes and reads, and the odd clear
  task automatic queue_random_commands(input int count);
    int                sent;
    int                pick;
    int                burst;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  c;
    logic [POS_W-1:0]  r;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        burst = $urandom_range(20, 4);
        repeat (burst) queue_command(FN_PUT_CHAR, CH_NEWLINE, 8'($urandom), 8'($urandom));
        sent += burst;
      end else if (pick < 4) begin
        burst = $urandom_range(100, 40);
        repeat (burst) begin
          queue_command(FN_PUT_CHAR, 8'($urandom_range(LAST_PRINTABLE, FIRST_PRINTABLE)),
                        8'($urandom), 8'($urandom));
        end
        sent += burst;
      end else if (pick < 6) begin
        queue_command(FN_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
        sent++;
      end else if (pick < 60) begin
        case ($urandom_range(9))
          0:       ch = CH_NEWLINE;
          1:       ch = CH_BACKSPACE;
          2:       ch = CH_RETURN;
          3:       ch = 8'($urandom);
          default: ch = 8'($urandom_range(LAST_PRINTABLE, FIRST_PRINTABLE));
        endcase
        queue_command(FN_PUT_CHAR, ch, 8'($urandom), 8'($urandom));
        sent++;
      end else if (pick < 78) begin
        ch = ($urandom_range(99) < 85) ? 8'($urandom_range(LAST_PRINTABLE, FIRST_PRINTABLE))
                                       : 8'($urandom);
        c  = ($urandom_range(99) < 80) ? 8'($urandom_range(COLUMNS - 1)) : 8'($urandom);
        r  = ($urandom_range(99) < 80) ? 8'($urandom_range(ROWS - 1)) : 8'($urandom);
        queue_command(FN_WRITE_CELL, ch, c, r);
        sent++;
      end else begin
        // reads lean toward the bottom rows where text and scrolls land
        c = ($urandom_range(99) < 85) ? 8'($urandom_range(COLUMNS - 1)) : 8'($urandom);
        case ($urandom_range(9))
          0, 1, 2, 3: r = 8'($urandom_range(ROWS - 1, ROWS - 5));
          4:          r = 8'($urandom);
          default:    r = 8'($urandom_range(ROWS - 1));
        endcase
        queue_command(FN_READ_CELL, 8'($urandom), c, r);
        sent++;
      end
    end
  endtask

  // sender holds back until every result is in, then the engine is idle
  task automatic wait_until_drained();
    while (reports_checked != commands_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_text_attribute(input logic [ATTR_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_attr = value;
  endtask

  initial begin
    model_attr = ATTR_RESET;
    blank_screen_model();

    // the engine blanks its store after this, with in_stall held high
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed commands, reset attribute
    send_idle_pct = 28;
    recv_idle_pct = 81;
    queue_command(FN_READ_CELL,  8'h00, 8'd0,   8'd0);    // corner cells after reset
    queue_command(FN_READ_CELL,  8'hFF, 8'd79,  8'd24);
    queue_command(FN_READ_CELL,  8'h00, 8'd80,  8'd0);    // column off screen
    queue_command(FN_READ_CELL,  8'h00, 8'd0,   8'd25);   // row off screen
    queue_command(FN_READ_CELL,  8'h00, 8'd255, 8'd255);
    queue_command(FN_PUT_CHAR,   8'h41, 8'd0,   8'd0);    // 'A'
    queue_command(FN_PUT_CHAR,   8'h00, 8'd255, 8'd255);  // ignored bytes
    queue_command(FN_PUT_CHAR,   8'h7F, 8'd0,   8'd0);
    queue_command(FN_PUT_CHAR,   8'hFF, 8'd0,   8'd0);
    queue_command(FN_PUT_CHAR,   FIRST_PRINTABLE, 8'd0, 8'd0);
    queue_command(FN_PUT_CHAR,   LAST_PRINTABLE,  8'd0, 8'd0);
    queue_command(FN_PUT_CHAR,   8'h1F, 8'd0,   8'd0);
    queue_command(FN_PUT_CHAR,   CH_RETURN,    8'd0, 8'd0);
    queue_command(FN_PUT_CHAR,   CH_BACKSPACE, 8'd0, 8'd0);  // at origin: no effect
    queue_command(FN_WRITE_CELL, 8'h5A, 8'd79,  8'd24);   // 'Z' in the last cell
    queue_command(FN_WRITE_CELL, 8'h51, 8'd80,  8'd3);    // off screen: dropped
    queue_command(FN_WRITE_CELL, 8'h51, 8'd2,   8'd25);
    queue_command(FN_WRITE_CELL, 8'h7F, 8'd1,   8'd1);    // not printable: dropped
    queue_command(FN_READ_CELL,  8'h00, 8'd79,  8'd24);
    queue_command(FN_PUT_CHAR,   CH_NEWLINE,   8'd0, 8'd0);
    queue_command(FN_PUT_CHAR,   CH_BACKSPACE, 8'd0, 8'd0);  // wraps up to the last column
    queue_command(FN_PUT_CHAR,   8'h23, 8'd0,   8'd0);    // '#' at line end wraps
    queue_command(FN_READ_CELL,  8'h00, 8'd79,  8'd0);
    queue_command(FN_CLEAR,      8'h00, 8'd0,   8'd0);
    queue_command(FN_READ_CELL,  8'h00, 8'd1,   8'd1);
    wait_until_drained();

    // phase 1: all-ones attribute, sender idles a little, receiver a lot
    phase = 1;
    write_text_attribute(8'hFF);
    queue_random_commands(240);
    wait_until_drained();

    // phase 2: zero attribute, idle rates swapped
    phase = 2;
    send_idle_pct = 81;
    recv_idle_pct = 28;
    write_text_attribute(8'h00);
    queue_random_commands(240);
    wait_until_drained();

    // phase 3: random attribute, no idling, long receiver hold-off up front
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_text_attribute(8'($urandom_range(254, 1)));
    phase = 3;
    queue_random_commands(240);
    wait_until_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/tcce_pkg.sv
rtl/core/tcce_ctrl.sv
rtl/core/tcce_dp.sv
rtl/core/text_console_char_engine.sv
dv/text_console_char_engine_tb.sv
